/* hdl/cfr_pkg.sv */
package cfr_pkg;

  localparam int CORDIC_STEPS    = 16;
  localparam int ANGLE_FRAC_BITS = 18;

  localparam int ANG_W     = 24;
  localparam int OPND_W    = 17;
  localparam int XY_W      = OPND_W + 10;
  localparam int TAB_LEN   = 24;
  localparam int TAB_FRAC  = 30;
  localparam int TAB_IDX_W = $clog2(TAB_LEN);
  localparam int ITER_W    = $clog2(CORDIC_STEPS);

  localparam longint ATAN_TAB [TAB_LEN] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287,
    262143, 131071, 65535, 32767, 16383, 8191,
    4095, 2047, 1023, 511, 255, 127
  };
  localparam longint HALF_PI_TAB = 1686629713;

  localparam logic [15:0] GYRO_WEIGHT_RESET     = 16'd64881;
  localparam logic [15:0] GYRO_STEP_SCALE_RESET = 16'd9152;

  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic signed [XY_W-1:0]  xy_t;

  localparam angle_t ANG_MAX = angle_t'(24'h7fffff);
  localparam angle_t ANG_MIN = angle_t'(24'h800000);

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
  } sample_t;

  typedef struct packed {
    angle_t roll_out;
    angle_t pitch_out;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } cordic_stat_t;

  typedef enum logic [0:0] {
    REG_GYRO_WEIGHT,
    REG_GYRO_STEP_SCALE
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROLL_ATAN,
    ST_MUL_RATE,
    ST_DIFF,
    ST_MUL_HI,
    ST_MUL_LO,
    ST_ACC,
    ST_ROUND,
    ST_PITCH_ATAN
  } state_t;

  // Rounds a table entry half up to the angle format.
  function automatic angle_t tab_to_angle(input longint t);
    longint r;
    r = (t + (longint'(1) <<< (TAB_FRAC - 1 - ANGLE_FRAC_BITS)))
        >>> (TAB_FRAC - ANGLE_FRAC_BITS);
    return angle_t'(r);
  endfunction

endpackage

/* hdl/cfr_cordic.sv */
module cfr_cordic (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [cfr_pkg::OPND_W-1:0]   num,
  input  logic signed [cfr_pkg::OPND_W-1:0]   den,
  output cfr_pkg::cordic_stat_t               stat,
  output cfr_pkg::angle_t                     angle
);
  import cfr_pkg::*;

  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(CORDIC_STEPS - 1);
  localparam angle_t HALF_PI = tab_to_angle(HALF_PI_TAB);

  xy_t               x;
  xy_t               y;
  angle_t            z;
  logic [ITER_W-1:0] iter;
  logic              zero;
  logic              busy;
  logic              done;

  xy_t    x0;
  xy_t    y0;
  xy_t    x_load;
  xy_t    y_load;
  angle_t z_load;
  xy_t    dx;
  xy_t    dy;
  angle_t step_ang;

  always_comb begin
    x0 = xy_t'(den) <<< 8;
    y0 = xy_t'(num) <<< 8;
    x_load = x0;
    y_load = y0;
    z_load = '0;
    if (x0 < 0) begin
      if (y0 >= 0) begin
        x_load = y0;
        y_load = -x0;
        z_load = HALF_PI;
      end else begin
        x_load = -y0;
        y_load = x0;
        z_load = -HALF_PI;
      end
    end
    dx = y >>> iter;
    dy = x >>> iter;
    step_ang = tab_to_angle(ATAN_TAB[TAB_IDX_W'(iter)]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && iter == LAST_ITER) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= x_load;
      y    <= y_load;
      z    <= z_load;
      iter <= '0;
      zero <= (num == '0) && (den == '0);
    end else if (busy) begin
      if (y >= 0) begin
        x <= x + dx;
        y <= y - dy;
        z <= z + step_ang;
      end else begin
        x <= x - dx;
        y <= y + dy;
        z <= z - step_ang;
      end
      iter <= iter + 1'b1;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign angle     = zero ? '0 : z;

endmodule

/* hdl/complementary_filter_roll_pitch.sv */
// Complementary roll and pitch filter for a raw IMU stream.
// A sample beat carries three accelerometer axes and the X and Y gyro rates.
// For each sample the block computes the accelerometer tilt angles with one
// iterative CORDIC unit, advances the stored roll and pitch by the gyro
// rates, blends the two estimates and returns one result beat with the new
// angles in radians with 18 fractional bits, saturated to 24 bits.
// A new sample is taken only once the previous one has been processed and
// its result loaded into the output register. Each sample takes two CORDIC
// runs of 16 iterations each plus one pass through the shared multiplier
// for each angle; the roll blend overlaps the pitch CORDIC run.
// The configuration channel writes the gyro weight and the gyro step scale;
// it is always ready and should be used only while the block is idle.
// Reset clears both stored angles, loads the default weight and step scale,
// and empties the result register. If the receiver stalls, the finished
// result waits in the output register, and one further sample is accepted
// and processed; it then holds until the output register is free.
module complementary_filter_roll_pitch (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_ready,
  input  cfr_pkg::sample_t     sample,
  output logic                 result_valid,
  input  logic                 result_ready,
  output cfr_pkg::result_t     result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfr_pkg::cfg_reg_t    cfg_index,
  input  logic [15:0]          cfg_data
);
  import cfr_pkg::*;

  localparam int UP_SHIFT  = 32 - ANGLE_FRAC_BITS;
  localparam int RND_SHIFT = 48 - ANGLE_FRAC_BITS;
  localparam int DIFF_W    = ANG_W + 2 + UP_SHIFT;
  localparam int MA_W      = DIFF_W - 16;
  localparam int PROD_W    = MA_W + 17;
  localparam int SUM_W     = DIFF_W + 18;
  localparam int RQ_W      = SUM_W - RND_SHIFT;

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [RQ_W-1:0]  RQ_MAX   = RQ_W'(ANG_MAX);
  localparam logic signed [RQ_W-1:0]  RQ_MIN   = RQ_W'(ANG_MIN);

  state_t state;
  state_t state_next;

  logic [15:0] gyro_weight;
  logic [15:0] gyro_step_scale;

  sample_t                   smp;
  logic                      axis;
  angle_t                    roll_angle;
  angle_t                    pitch_angle;
  angle_t                    acc;
  logic signed [PROD_W-1:0]  prod;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SUM_W-1:0]   sum;

  logic                      accept;
  logic                      out_free;
  logic                      cstart;
  logic signed [OPND_W-1:0]  cnum;
  logic signed [OPND_W-1:0]  cden;
  cordic_stat_t              cstat;
  angle_t                    cangle;

  logic signed [MA_W-1:0]    mul_a;
  logic signed [16:0]        mul_b;
  angle_t                    cur_angle;
  logic signed [15:0]        cur_rate;
  logic signed [ANG_W:0]     ang_diff;
  logic signed [SUM_W-1:0]   rsum;
  logic signed [RQ_W-1:0]    rq;
  angle_t                    sat;

  cfr_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .num   (cnum),
    .den   (cden),
    .stat  (cstat),
    .angle (cangle)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_weight     <= GYRO_WEIGHT_RESET;
      gyro_step_scale <= GYRO_STEP_SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GYRO_WEIGHT:     gyro_weight     <= cfg_data;
        REG_GYRO_STEP_SCALE: gyro_step_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    accept    = (state == ST_IDLE) && sample_valid;
    out_free  = !result_valid || result_ready;
    cur_angle = axis ? pitch_angle : roll_angle;
    cur_rate  = axis ? smp.rate_y : smp.rate_x;
    ang_diff  = (ANG_W + 1)'(cur_angle) - (ANG_W + 1)'(acc);
    rsum      = sum + RND_HALF;
    rq        = rsum[SUM_W-1:RND_SHIFT];
    if (rq > RQ_MAX) begin
      sat = ANG_MAX;
    end else if (rq < RQ_MIN) begin
      sat = ANG_MIN;
    end else begin
      sat = angle_t'(rq);
    end
  end

  always_comb begin
    state_next   = state;
    sample_ready = 1'b0;
    cstart       = 1'b0;
    cnum         = -OPND_W'(smp.accel_x);
    cden         = OPND_W'(smp.accel_z);
    mul_a        = MA_W'(cur_rate);
    mul_b        = $signed({1'b0, gyro_step_scale});
    unique case (state)
      ST_IDLE: begin
        sample_ready = 1'b1;
        cnum         = OPND_W'(sample.accel_y);
        cden         = OPND_W'(sample.accel_z);
        if (sample_valid) begin
          cstart     = 1'b1;
          state_next = ST_ROLL_ATAN;
        end
      end
      ST_ROLL_ATAN: begin
        if (cstat.done) begin
          cstart     = 1'b1;
          state_next = ST_MUL_RATE;
        end
      end
      ST_MUL_RATE: state_next = ST_DIFF;
      ST_DIFF:     state_next = ST_MUL_HI;
      ST_MUL_HI: begin
        mul_a      = diff[DIFF_W-1:16];
        mul_b      = $signed({1'b0, gyro_weight});
        state_next = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        mul_a      = $signed({{(MA_W - 16){1'b0}}, diff[15:0]});
        mul_b      = $signed({1'b0, gyro_weight});
        state_next = ST_ACC;
      end
      ST_ACC: state_next = ST_ROUND;
      ST_ROUND: begin
        if (!axis) begin
          state_next = ST_PITCH_ATAN;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_PITCH_ATAN: begin
        if (cstat.done) begin
          state_next = ST_MUL_RATE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      axis         <= 1'b0;
      roll_angle   <= '0;
      pitch_angle  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (state == ST_ROUND && axis && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        axis <= 1'b0;
      end
      if (state == ST_PITCH_ATAN && cstat.done) begin
        axis <= 1'b1;
      end
      if (state == ST_ROUND) begin
        if (!axis) begin
          roll_angle <= sat;
        end else if (out_free) begin
          pitch_angle      <= sat;
          result.roll_out  <= roll_angle;
          result.pitch_out <= sat;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= sample;
    end
    if ((state == ST_ROLL_ATAN || state == ST_PITCH_ATAN) && cstat.done) begin
      acc <= cangle;
    end
    prod <= mul_a * mul_b;
    unique case (state)
      ST_DIFF: begin
        diff <= (DIFF_W'(ang_diff) <<< UP_SHIFT) + $signed(prod[DIFF_W-1:0]);
        sum  <= SUM_W'(acc) <<< RND_SHIFT;
      end
      ST_MUL_LO: sum <= sum + (SUM_W'(prod) <<< 16);
      ST_ACC:    sum <= sum + SUM_W'(prod);
      default: ;
    endcase
  end

  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cstat.done |-> (state == ST_ROLL_ATAN || state == ST_PITCH_ATAN))
    else $error("CORDIC finished outside a wait state.");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && sample_ready) |=> cstat.busy)
    else $error("Accepted sample did not start the CORDIC unit.");

  a_roll_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL_RATE && !axis) |-> cstat.busy)
    else $error("Pitch CORDIC run not active during the roll blend.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == ST_ROUND && axis))
    else $error("Result raised outside the final pitch rounding step.");

endmodule

/* sim/cfr_checker.sv */
module cfr_checker (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  input  logic                 sample_ready,
  input  cfr_pkg::sample_t     sample,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  cfr_pkg::result_t     result,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  cfr_pkg::cfg_reg_t    cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   fails,
  output int                   outstanding
);
  import cfr_pkg::*;

  localparam int TAB_SHIFT = TAB_FRAC - ANGLE_FRAC_BITS;

  angle_t      roll_est;
  angle_t      pitch_est;
  logic [15:0] weight;
  logic [15:0] step_scale;
  result_t     pending_angles [$];
  int          mismatches;

  initial begin
    fails       = 0;
    outstanding = 0;
    mismatches  = 0;
  end

  function automatic longint round_tab(input longint t);
    return (t + (longint'(1) <<< (TAB_SHIFT - 1))) >>> TAB_SHIFT;
  endfunction

  function automatic longint tilt_angle(input longint num, input longint den);
    longint x;
    longint y;
    longint z;
    longint nx;
    longint dx;
    longint dy;
    longint a;
    if (num == 0 && den == 0) begin
      return 0;
    end
    x = den * 256;
    y = num * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        nx = y;
        y  = -x;
        x  = nx;
        z  = round_tab(HALF_PI_TAB);
      end else begin
        nx = -y;
        y  = x;
        x  = nx;
        z  = -round_tab(HALF_PI_TAB);
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < TAB_LEN; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      a  = round_tab(ATAN_TAB[i]);
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + a;
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - a;
      end
    end
    return z;
  endfunction

  function automatic angle_t fuse(input longint angle, input longint rate, input longint acc,
                                  input longint w, input longint scale);
    longint up;
    longint pred;
    longint sum;
    longint r;
    up   = longint'(1) <<< (32 - ANGLE_FRAC_BITS);
    pred = angle * up + rate * scale;
    sum  = w * pred + (65536 - w) * (acc * up);
    r    = (sum + (longint'(1) <<< (47 - ANGLE_FRAC_BITS))) >>> (48 - ANGLE_FRAC_BITS);
    if (r > longint'(ANG_MAX)) begin
      r = longint'(ANG_MAX);
    end
    if (r < longint'(ANG_MIN)) begin
      r = longint'(ANG_MIN);
    end
    return angle_t'(r);
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    longint  ax;
    longint  ay;
    longint  az;
    if (rst) begin
      roll_est   = '0;
      pitch_est  = '0;
      weight     = GYRO_WEIGHT_RESET;
      step_scale = GYRO_STEP_SCALE_RESET;
      pending_angles.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GYRO_WEIGHT:     weight     = cfg_data;
          REG_GYRO_STEP_SCALE: step_scale = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && result_ready) begin
        if (pending_angles.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected result beat: roll %0d pitch %0d",
                     result.roll_out, result.pitch_out);
          end
        end else begin
          want = pending_angles.pop_front();
          if (result.roll_out !== want.roll_out || result.pitch_out !== want.pitch_out) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Angle mismatch: roll exp %0d got %0d, pitch exp %0d got %0d",
                       want.roll_out, result.roll_out, want.pitch_out, result.pitch_out);
            end
          end
        end
      end
      if (sample_valid && sample_ready) begin
        ax = longint'($signed(sample.accel_x));
        ay = longint'($signed(sample.accel_y));
        az = longint'($signed(sample.accel_z));
        roll_est  = fuse(longint'(roll_est), longint'($signed(sample.rate_x)),
                         tilt_angle(ay, az), longint'(weight), longint'(step_scale));
        pitch_est = fuse(longint'(pitch_est), longint'($signed(sample.rate_y)),
                         tilt_angle(-ax, az), longint'(weight), longint'(step_scale));
        want.roll_out  = roll_est;
        want.pitch_out = pitch_est;
        pending_angles.push_back(want);
      end
    end
    fails       <= mismatches;
    outstanding <= pending_angles.size();
  end

endmodule

/* sim/tb_complementary_filter_roll_pitch.sv */
module tb_complementary_filter_roll_pitch;
  import cfr_pkg::*;

  localparam int STALL_LIMIT = 4000;

  logic        clk = 1'b0;
  logic        rst;
  logic        sample_valid;
  logic        sample_ready;
  sample_t     sample;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_valid;
  logic        cfg_ready;
  cfg_reg_t    cfg_index;
  logic [15:0] cfg_data;
  logic        calm = 1'b0;
  int          fails;
  int          outstanding;
  int          quiet_cycles = 0;

  complementary_filter_roll_pitch u_top (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  cfr_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fails        (fails),
    .outstanding  (outstanding)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= calm || ($urandom_range(0, 99) >= 22);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [15:0] pick_field();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3:       return 16'($signed($urandom_range(0, 31)) - 16);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_reg();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'hffff - 16'($urandom_range(0, 1500));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send(input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
                      input logic [15:0] rx, input logic [15:0] ry);
    int gap;
    gap = 0;
    if (!calm) begin
      while ($urandom_range(0, 99) < 22) gap++;
      if ($urandom_range(0, 7) == 0) gap += $urandom_range(1, 45);
    end
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample       <= '{accel_x: ax, accel_y: ay, accel_z: az, rate_x: rx, rate_y: ry};
    sample_valid <= 1'b1;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic send_random();
    send(pick_field(), pick_field(), pick_field(), pick_field(), pick_field());
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_filter(input logic [15:0] w, input logic [15:0] scale);
    write_reg(REG_GYRO_WEIGHT, w);
    write_reg(REG_GYRO_STEP_SCALE, scale);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst          <= 1'b1;
    sample_valid <= 1'b0;
    sample       <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_GYRO_WEIGHT;
    cfg_data     <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0000, 16'h8000, 16'h7fff, 16'h8000);
    send(16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff);
    send(16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send(16'h7fff, 16'h8000, 16'h8000, 16'h0001, 16'hffff);
    send(16'h8000, 16'h7fff, 16'h7fff, 16'hffff, 16'h0001);
    send(16'h0001, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
    send(16'hffff, 16'h0001, 16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'h8000, 16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'h7fff, 16'h0000, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0001, 16'hffff, 16'h0000, 16'h0000);
    send(16'h0000, 16'hffff, 16'hffff, 16'h0000, 16'h0000);
    send(16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
    send(16'h4000, 16'hc000, 16'h4000, 16'h1234, 16'hedcb);
    send(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555);
    send(16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
    drain();

    set_filter(16'hffff, 16'hffff);
    repeat (90) send(pick_field(), pick_field(), pick_field(), 16'h7fff, 16'h8000);
    repeat (90) send(pick_field(), pick_field(), pick_field(), 16'h8000, 16'h7fff);
    repeat (40) send_random();
    drain();

    set_filter(16'h0000, 16'h0000);
    repeat (150) send_random();
    drain();

    set_filter(16'h0000, 16'hffff);
    repeat (150) send_random();
    drain();

    set_filter(16'hffff, 16'h0000);
    repeat (150) send_random();
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      set_filter(pick_reg(), pick_reg());
      calm <= (phase == 2);
      repeat (220) send_random();
      drain();
    end
    calm <= 1'b0;

    set_filter(GYRO_WEIGHT_RESET, GYRO_STEP_SCALE_RESET);
    repeat (100) send_random();
    drain();

    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/cfr_pkg.sv
hdl/cfr_cordic.sv
hdl/complementary_filter_roll_pitch.sv
sim/cfr_checker.sv
sim/tb_complementary_filter_roll_pitch.sv
